// ===== src/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared widths, defaults and instruction codes for the subset executor.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int DATA_WORDS_DEF = 1024;
  localparam int REG_COUNT_DEF  = 32;

  localparam int INSTR_W    = 32;
  localparam int INDEX_W    = 16;
  localparam int XLEN       = 32;
  localparam int REG_W      = 5;
  localparam int MADDR_W    = 10;
  localparam int NEXT_W     = 20;

  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;

  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_AND = 3'b011;
  localparam logic [2:0] F3_OR  = 3'b100;

endpackage

// ===== src/rvx_if.sv =====
// ----------------------------------------------------------------------------
// rvx channel interfaces
// Valid/ready channels for instructions in and execution results out.
// ----------------------------------------------------------------------------
interface rvx_in_if;
  logic                         valid;
  logic                         ready;
  logic [rvx_pkg::INSTR_W-1:0]  instruction;
  logic [rvx_pkg::INDEX_W-1:0]  instr_index;

  modport source (output valid, output instruction, output instr_index, input ready);
  modport sink   (input valid, input instruction, input instr_index, output ready);
endinterface

interface rvx_out_if;
  logic                               valid;
  logic                               ready;
  logic                               wrote_register;
  logic [rvx_pkg::REG_W-1:0]          dest_register;
  logic signed [rvx_pkg::XLEN-1:0]    write_value;
  logic                               stored_to_memory;
  logic [rvx_pkg::MADDR_W-1:0]        memory_address;
  logic                               redirect;
  logic signed [rvx_pkg::NEXT_W-1:0]  next_index;

  modport source (output valid, output wrote_register, output dest_register,
                  output write_value, output stored_to_memory, output memory_address,
                  output redirect, output next_index, input ready);
  modport sink   (input valid, input wrote_register, input dest_register,
                  input write_value, input stored_to_memory, input memory_address,
                  input redirect, input next_index, output ready);
endinterface

// ===== src/rv_subset_instruction_executor_unit.sv =====
// stages: register file read, execute with data memory access, result register;
//   each advances only when the next is free, so rsp.ready can stall the pipe
// throughput: one instruction per cycle when not stalled; back-to-back results forwarded
// reset: register file valid bits clear at once; data memory is swept to zero,
//   one word a cycle over every address after reset, during which req.ready is low
// ----------------------------------------------------------------------------
// rv_subset_instruction_executor_unit
// Executes one instruction of a small integer subset per transaction against a
// register file and a word-addressed data memory.
// ----------------------------------------------------------------------------
module rv_subset_instruction_executor_unit #(
  parameter int DATA_WORDS = rvx_pkg::DATA_WORDS_DEF,
  parameter int REG_COUNT  = rvx_pkg::REG_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rvx_in_if.sink    req,
  rvx_out_if.source rsp
);

  localparam int  AW   = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int  RW   = $clog2(REG_COUNT);
  localparam int  XL   = rvx_pkg::XLEN;
  localparam int  NW   = rvx_pkg::NEXT_W;
  localparam bit  POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

  // storage
  logic [XL-1:0]        rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;
  logic [XL-1:0]        dmem [DATA_WORDS];

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // stage 1
  logic                        v1;
  logic [rvx_pkg::INSTR_W-1:0] s1_instr;
  logic [rvx_pkg::INDEX_W-1:0] s1_index;
  logic [XL-1:0]               rf1_q, rf2_q;
  logic                        rf1_ok, rf2_ok;
  logic                        byp1_hit, byp2_hit;
  logic [XL-1:0]               byp_val;

  // stage 2
  logic                        v2;
  logic                        s2_wr;
  logic [rvx_pkg::REG_W-1:0]   s2_rd;
  logic [XL-1:0]               s2_alu;
  logic                        s2_load;
  logic                        s2_st;
  logic [rvx_pkg::MADDR_W-1:0] s2_maddr;
  logic                        s2_redir;
  logic [NW-1:0]               s2_next;
  logic [XL-1:0]               mem_q;

  // result register
  logic out_v;

  logic adv_out, adv2, adv1, acc, rf_we;
  logic [XL-1:0] s2_wval;

  assign adv_out   = !out_v || rsp.ready;
  assign adv2      = !v2 || adv_out;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1 && !clearing;
  assign acc       = req.valid && req.ready;
  assign rsp.valid = out_v;

  assign s2_wval = s2_load ? mem_q : s2_alu;
  assign rf_we   = v2 && s2_wr && adv_out;

  // decode
  logic [6:0]                op;
  logic [rvx_pkg::REG_W-1:0] rd, rs1, rs2;
  logic [2:0]                f3;
  logic                      bit30;
  logic [XL-1:0]             imm_i, imm_s, imm_j;

  assign op    = s1_instr[6:0];
  assign rd    = s1_instr[11:7];
  assign f3    = s1_instr[14:12];
  assign rs1   = s1_instr[19:15];
  assign rs2   = s1_instr[24:20];
  assign bit30 = s1_instr[30];
  assign imm_i = {{20{s1_instr[31]}}, s1_instr[31:20]};
  assign imm_s = {{20{s1_instr[31]}}, s1_instr[31:25], s1_instr[11:7]};
  assign imm_j = {{12{s1_instr[31]}}, s1_instr[31:12]};

  // operands, newest write first
  logic [XL-1:0] opa, opb;
  logic          s2_hit1, s2_hit2;

  assign s2_hit1 = v2 && s2_wr && (s2_rd == rs1);
  assign s2_hit2 = v2 && s2_wr && (s2_rd == rs2);
  assign opa = s2_hit1 ? s2_wval : (byp1_hit ? byp_val : (rf1_ok ? rf1_q : '0));
  assign opb = s2_hit2 ? s2_wval : (byp2_hit ? byp_val : (rf2_ok ? rf2_q : '0));

  function automatic logic [XL-1:0] alu(input logic [XL-1:0] x, input logic [XL-1:0] y,
                                        input logic [2:0] f, input logic sb);
    logic [XL-1:0] r;
    r = '0;
    if (f == rvx_pkg::F3_ADD) begin
      r = sb ? (x - y) : (x + y);
    end else if (!sb) begin
      if (f == rvx_pkg::F3_AND) begin
        r = x & y;
      end else if (f == rvx_pkg::F3_OR) begin
        r = x | y;
      end
    end
    return r;
  endfunction

  logic          s1_wr, s1_st, s1_load, s1_redir;
  logic [XL-1:0] s1_val;
  logic [NW-1:0] s1_next;
  logic [XL-1:0] s1_sum;
  logic [AW-1:0] s1_addr;
  logic          s1_mem;

  always_comb begin
    s1_wr    = 1'b0;
    s1_st    = 1'b0;
    s1_load  = 1'b0;
    s1_redir = 1'b0;
    s1_mem   = 1'b0;
    s1_val   = '0;
    s1_next  = NW'(s1_index) + NW'(1);
    case (op)
      rvx_pkg::OP_REG: begin
        s1_wr  = 1'b1;
        s1_val = alu(opa, opb, f3, bit30);
      end
      rvx_pkg::OP_IMM: begin
        s1_wr  = 1'b1;
        s1_val = alu(opa, imm_i, f3, 1'b0);
      end
      rvx_pkg::OP_LOAD: begin
        s1_wr   = 1'b1;
        s1_load = 1'b1;
        s1_mem  = 1'b1;
      end
      rvx_pkg::OP_STORE: begin
        s1_st  = 1'b1;
        s1_mem = 1'b1;
      end
      rvx_pkg::OP_BRANCH: begin
        if (opa == opb) begin
          s1_redir = 1'b1;
          s1_next  = imm_s[NW-1:0];
        end
      end
      rvx_pkg::OP_JAL: begin
        s1_wr    = 1'b1;
        s1_val   = XL'(s1_index) + XL'(1);
        s1_redir = 1'b1;
        s1_next  = imm_j[NW-1:0];
      end
      rvx_pkg::OP_JALR: begin
        s1_wr    = 1'b1;
        s1_val   = XL'(s1_index) + XL'(1);
        s1_redir = 1'b1;
        s1_next  = imm_i[NW-1:0];
      end
      default: begin
        s1_wr = 1'b0;
      end
    endcase
  end

  assign s1_sum = opa + ((op == rvx_pkg::OP_STORE) ? imm_s : imm_i);

  // address wrap to the memory size
  generate
    if (POW2) begin : g_mask
      assign s1_addr = s1_sum[AW-1:0];
    end else begin : g_fold
      // per-byte residue tables, summed and brought below the size in two steps
      logic [15:0] res_tbl [4][256];
      logic [17:0] rsum, rsum_a, rsum_b;
      for (genvar k = 0; k < 4; k++) begin : g_pos
        for (genvar b = 0; b < 256; b++) begin : g_ent
          localparam logic [15:0] RV = 16'(((64'(b)) << (8 * k)) % DATA_WORDS);
          assign res_tbl[k][b] = RV;
        end
      end
      assign rsum = 18'(res_tbl[0][s1_sum[7:0]])   + 18'(res_tbl[1][s1_sum[15:8]]) +
                    18'(res_tbl[2][s1_sum[23:16]]) + 18'(res_tbl[3][s1_sum[31:24]]);
      assign rsum_a = (rsum >= 18'(2 * DATA_WORDS)) ? (rsum - 18'(2 * DATA_WORDS)) : rsum;
      assign rsum_b = (rsum_a >= 18'(DATA_WORDS)) ? (rsum_a - 18'(DATA_WORDS)) : rsum_a;
      assign s1_addr = rsum_b[AW-1:0];
    end
  endgenerate

  // clearing pass and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      out_v    <= 1'b0;
      rf_valid <= '0;
    end else begin
      if (clearing) begin
        if (clr_addr == AW'(DATA_WORDS - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + AW'(1);
      end
      if (adv1) begin
        v1 <= acc;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv_out) begin
        out_v <= v2;
      end
      if (rf_we) begin
        rf_valid[s2_rd[RW-1:0]] <= 1'b1;
      end
    end
  end

  // register file: registered reads at acceptance, write on retire
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[s2_rd[RW-1:0]] <= s2_wval;
    end
    if (acc) begin
      s1_instr <= req.instruction;
      s1_index <= req.instr_index;
      rf1_q    <= rf[req.instruction[15+RW-1:15]];
      rf2_q    <= rf[req.instruction[20+RW-1:20]];
      rf1_ok   <= rf_valid[req.instruction[15+RW-1:15]];
      rf2_ok   <= rf_valid[req.instruction[20+RW-1:20]];
      // the read above misses the write retiring at this same edge
      byp1_hit <= rf_we && (s2_rd == req.instruction[19:15]);
      byp2_hit <= rf_we && (s2_rd == req.instruction[24:20]);
      byp_val  <= s2_wval;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_addr] <= '0;
    end else if (v1 && adv2 && s1_st) begin
      dmem[s1_addr] <= opb;
    end
    if (v1 && adv2 && s1_load) begin
      mem_q <= dmem[s1_addr];
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2_wr    <= s1_wr && (rd != '0);
      s2_rd    <= rd;
      s2_alu   <= s1_val;
      s2_load  <= s1_load;
      s2_st    <= s1_st;
      s2_maddr <= s1_mem ? rvx_pkg::MADDR_W'(s1_addr) : '0;
      s2_redir <= s1_redir;
      s2_next  <= s1_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv_out && v2) begin
      rsp.wrote_register   <= s2_wr;
      rsp.dest_register    <= s2_wr ? s2_rd : '0;
      rsp.write_value      <= s2_wr ? s2_wval : '0;
      rsp.stored_to_memory <= s2_st;
      rsp.memory_address   <= s2_maddr;
      rsp.redirect         <= s2_redir;
      rsp.next_index       <= s2_next;
    end
  end

endmodule
